FILE: rtl/isqrt_pkg.sv
// Shared types and constants for the integer square root block.
`timescale 1ns / 1ps

package isqrt_pkg;

  localparam int OPERAND_W       = 64;  // operand field width
  localparam int ROOT_W          = 32;  // root field width
  localparam int INPUT_WIDTH_DEF = 64;  // default significant operand bits

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } isqrt_state_t;

endpackage

FILE: rtl/isqrt_step.sv
// One restoring digit step: trial subtract of the partial root from the remainder.
`timescale 1ns / 1ps

module isqrt_step import isqrt_pkg::*; #(
  parameter int RW = OPERAND_W
) (
  input  logic [RW-1:0] rem,
  input  logic [RW-1:0] acc,
  input  logic [RW-1:0] place,
  output logic [RW-1:0] rem_nxt,
  output logic [RW-1:0] acc_nxt
);

  logic [RW-1:0] trial;
  logic          fits;

  assign trial = acc + place;
  assign fits  = (rem >= trial);

  always_comb begin
    if (fits) begin
      rem_nxt = rem - trial;
      acc_nxt = (acc >> 1) + place;
    end else begin
      rem_nxt = rem;
      acc_nxt = acc >> 1;
    end
  end

endmodule

FILE: rtl/integer_square_root_64.sv
// Integer square root top level: sequencer, working registers and output register.
// Sequence: an accepted input beat loads the working registers and starts the digit loop,
//   one pass of the shared digit step per operand bit pair; the last pass writes the root.
// Flow: one operand at a time; in_stall is high while the digit loop runs, and a finished
//   root waits in the output register if out_stall holds.
// Reset: synchronous active-low rst_n clears the sequencer and out_valid; data regs are not reset.
`timescale 1ns / 1ps

module integer_square_root_64 import isqrt_pkg::*; #(
  parameter int INPUT_WIDTH = INPUT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OPERAND_W-1:0] in_operand,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ROOT_W-1:0]    out_root
);

  // Bit pairs of the operand, one digit step each; working width rounds up to whole pairs.
  localparam int PAIRS = (INPUT_WIDTH + 1) / 2;
  localparam int RW    = 2 * PAIRS;

  isqrt_state_t  state_r, state_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [RW-1:0] acc_r, acc_nxt;
  logic [RW-1:0] place_r, place_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0] out_root_r, out_root_nxt;

  logic [RW-1:0]        step_rem;
  logic [RW-1:0]        step_acc;
  logic [OPERAND_W-1:0] step_acc_ext;
  logic                 slot_free;
  logic                 finish;

  // Shared digit unit, fed from the working registers every RUN cycle.
  isqrt_step #(.RW(RW)) u_step (
    .rem     (rem_r),
    .acc     (acc_r),
    .place   (place_r),
    .rem_nxt (step_rem),
    .acc_nxt (step_acc)
  );

  assign step_acc_ext = OPERAND_W'(step_acc);

  // Output register can take a new root if empty or being drained this cycle.
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt    = state_r;
    rem_nxt      = rem_r;
    acc_nxt      = acc_r;
    place_nxt    = place_r;
    out_root_nxt = out_root_r;
    finish       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Bits above INPUT_WIDTH are dropped.
          rem_nxt   = RW'(in_operand[INPUT_WIDTH-1:0]);
          acc_nxt   = '0;
          place_nxt = RW'(1) << (RW - 2);
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!place_r[0]) begin
          rem_nxt   = step_rem;
          acc_nxt   = step_acc;
          place_nxt = place_r >> 2;
        end else if (slot_free) begin
          // Last pair: root goes straight to the output register.
          out_root_nxt = step_acc_ext[ROOT_W-1:0];
          finish       = 1'b1;
          state_nxt    = ST_IDLE;
        end
        // else: hold the last step until the output register frees up
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    acc_r      <= acc_nxt;
    place_r    <= place_nxt;
    out_root_r <= out_root_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

  // An accepted beat always starts the digit loop.
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_RUN))
    else $error("accepted operand did not start the digit loop");

  // Digit weight is a single bit for the whole loop.
  a_place_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> $onehot(place_r))
    else $error("digit weight lost its single set bit");

  // A new root only appears at the end of a loop.
  a_valid_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RUN))
    else $error("output valid rose outside the digit loop");

  // A waiting root is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !finish)
    else $error("finished root overwrote a pending result");

endmodule
